@@ rtl/core/alc_pkg.sv @@
`timescale 1ns / 1ps

package alc_pkg;

  // Operation codes carried in the kind field of a request.
  typedef enum logic [3:0] {
    K_PUSH_FRONT = 4'd0,
    K_PUSH_BACK  = 4'd1,
    K_INSERT     = 4'd2,
    K_POP_FRONT  = 4'd3,
    K_POP_BACK   = 4'd4,
    K_ERASE      = 4'd5,
    K_FIND       = 4'd6,
    K_MODIFY     = 4'd7,
    K_ERASE_ALL  = 4'd8
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // What every cell of the chain does.
  typedef enum logic [2:0] {
    CM_HOLD = 3'd0,
    CM_INS  = 3'd1,
    CM_DEL  = 3'd2,
    CM_WR   = 3'd3,
    CM_SCAN = 3'd4
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       wr;
  } cell_ctl_t;

  localparam int unsigned DATA_W = 32;

endpackage

@@ rtl/core/alc_cell.sv @@
`timescale 1ns / 1ps

module alc_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned ID    = 0
) (
  input  logic                       clk,
  input  alc_pkg::cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]           idx,
  input  logic [alc_pkg::DATA_W-1:0] data,
  input  logic [alc_pkg::DATA_W-1:0] left_q,
  input  logic [alc_pkg::DATA_W-1:0] right_q,
  output logic [alc_pkg::DATA_W-1:0] q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(ID);

  logic [alc_pkg::DATA_W-1:0] q_r;
  logic [alc_pkg::DATA_W-1:0] q_nxt;

  // Insert opens a gap at idx by taking the left neighbor; delete and scan
  // close it by taking the right neighbor.
  always_comb begin
    case (ctl.mode)
      alc_pkg::CM_INS: begin
        if (idx == MY_IDX) begin
          q_nxt = data;
        end else if (MY_IDX > idx) begin
          q_nxt = left_q;
        end else begin
          q_nxt = q_r;
        end
      end
      alc_pkg::CM_DEL:  q_nxt = (MY_IDX >= idx) ? right_q : q_r;
      alc_pkg::CM_WR:   q_nxt = (idx == MY_IDX) ? data : q_r;
      alc_pkg::CM_SCAN: q_nxt = (ctl.wr && idx == MY_IDX) ? data : right_q;
      default:          q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ rtl/core/array_list_engine_unit.sv @@
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words kept in a chain of cells.
// A request (in_kind, in_position, in_value) is taken when in_valid and
// in_ready are both high; every request gives exactly one result on the out_
// channel (status, found, found_index, removed, length), handed over when
// out_valid and out_ready are both high.
// Push, insert, pop, erase, modify and unused kinds finish in their accept cycle,
// shifting or writing cells as needed, so their result is valid in the next cycle.
// Find and erase-all rotate the list once through the chain head, one entry a
// cycle, and publish their result once the last entry has been examined; on an
// empty list they finish in their accept cycle like the others.
// The block works on one request at a time: in_ready is high only when no
// scan is running and the result register is empty or being emptied in the
// same cycle. A stalled receiver therefore holds off new requests once one
// result waits, but the pending result itself stays stable.
// Reset (rst_n low at a rising edge) empties the list and drops any result
// that was waiting. Cell contents are not cleared; only cells below the
// element count are ever read, and each of those was written first.
module array_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [3:0]  in_position,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [3:0]  out_found_index,
  output logic [4:0]  out_removed,
  output logic [4:0]  out_length
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned DW    = alc_pkg::DATA_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     left_r;
  logic [CNT_W-1:0]     tail_r;
  logic [IDX_W-1:0]     step_r;
  logic                 is_ea_r;
  logic                 found_r;
  logic [IDX_W-1:0]     fidx_r;
  logic [CNT_W-1:0]     removed_r;
  logic [DW-1:0]        val_r;

  logic                 out_valid_r;
  alc_pkg::status_t     out_status_r;
  logic                 out_found_r;
  logic [IDX_W-1:0]     out_fidx_r;
  logic [CNT_W-1:0]     out_removed_r;
  logic [CNT_W-1:0]     out_len_r;

  // Shared control broadcast to the cell chain.
  alc_pkg::cell_ctl_t   ctl;
  logic [IDX_W-1:0]     cidx;
  logic [DW-1:0]        cdata;
  logic [DW-1:0]        cell_q [CAPACITY];

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     pos_ext;
  logic [DW-1:0]        head;
  logic                 match;
  logic [CNT_W-1:0]     tail_dec;

  // Outcome of a request that finishes in its accept cycle.
  alc_pkg::status_t     imm_status;
  logic [CNT_W-1:0]     imm_cnt;
  logic                 go_scan;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign cnt_ext  = CMP_W'(count_r);
  assign pos_ext  = CMP_W'(in_position);
  assign head     = cell_q[0];
  assign match    = (head == val_r);
  assign tail_dec = tail_r - CNT_W'(1);

  always_comb begin
    ctl.mode   = alc_pkg::CM_HOLD;
    ctl.wr     = 1'b0;
    cidx       = '0;
    cdata      = in_value;
    imm_status = alc_pkg::ST_OK;
    imm_cnt    = count_r;
    go_scan    = 1'b0;
    if (state_r == S_SCAN) begin
      // Head leaves the chain; a kept entry re-enters just below the tail,
      // so survivors end up packed from cell zero in their old order.
      ctl.mode = alc_pkg::CM_SCAN;
      ctl.wr   = !is_ea_r || !match;
      cidx     = tail_dec[IDX_W-1:0];
      cdata    = head;
    end else if (accept) begin
      case (alc_pkg::kind_t'(in_kind))
        alc_pkg::K_PUSH_FRONT: begin
          if (full) begin
            imm_status = alc_pkg::ST_FULL;
          end else begin
            ctl.mode = alc_pkg::CM_INS;
            imm_cnt  = count_r + CNT_W'(1);
          end
        end
        alc_pkg::K_PUSH_BACK: begin
          if (full) begin
            imm_status = alc_pkg::ST_FULL;
          end else begin
            ctl.mode = alc_pkg::CM_WR;
            cidx     = count_r[IDX_W-1:0];
            imm_cnt  = count_r + CNT_W'(1);
          end
        end
        alc_pkg::K_INSERT: begin
          if (full) begin
            imm_status = alc_pkg::ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            imm_status = alc_pkg::ST_RANGE;
          end else begin
            ctl.mode = alc_pkg::CM_INS;
            cidx     = pos_ext[IDX_W-1:0];
            imm_cnt  = count_r + CNT_W'(1);
          end
        end
        alc_pkg::K_POP_FRONT: begin
          if (empty) begin
            imm_status = alc_pkg::ST_EMPTY;
          end else begin
            ctl.mode = alc_pkg::CM_DEL;
            imm_cnt  = count_r - CNT_W'(1);
          end
        end
        alc_pkg::K_POP_BACK: begin
          if (empty) begin
            imm_status = alc_pkg::ST_EMPTY;
          end else begin
            imm_cnt = count_r - CNT_W'(1);
          end
        end
        alc_pkg::K_ERASE: begin
          if (empty) begin
            imm_status = alc_pkg::ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            imm_status = alc_pkg::ST_RANGE;
          end else begin
            ctl.mode = alc_pkg::CM_DEL;
            cidx     = pos_ext[IDX_W-1:0];
            imm_cnt  = count_r - CNT_W'(1);
          end
        end
        alc_pkg::K_MODIFY: begin
          if (empty) begin
            imm_status = alc_pkg::ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            imm_status = alc_pkg::ST_RANGE;
          end else begin
            ctl.mode = alc_pkg::CM_WR;
            cidx     = pos_ext[IDX_W-1:0];
          end
        end
        alc_pkg::K_FIND, alc_pkg::K_ERASE_ALL: begin
          go_scan = !empty;
        end
        default: begin
        end
      endcase
    end
  end

  // The chain: cell zero is the list head, cell CAPACITY-1 the far end.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left_d;
    logic [DW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = cdata;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    alc_cell #(
      .IDX_W (IDX_W),
      .ID    (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (cidx),
      .data    (cdata),
      .left_q  (left_d),
      .right_q (right_d),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A request that finishes at once refills the result register itself.
      if (out_valid_r && out_ready && !(accept && !go_scan)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            val_r     <= in_value;
            is_ea_r   <= (alc_pkg::kind_t'(in_kind) == alc_pkg::K_ERASE_ALL);
            found_r   <= 1'b0;
            fidx_r    <= '0;
            removed_r <= '0;
            step_r    <= '0;
            left_r    <= count_r;
            tail_r    <= count_r;
            if (go_scan) begin
              state_r <= S_SCAN;
            end else begin
              count_r       <= imm_cnt;
              out_valid_r   <= 1'b1;
              out_status_r  <= imm_status;
              out_found_r   <= 1'b0;
              out_fidx_r    <= '0;
              out_removed_r <= '0;
              out_len_r     <= imm_cnt;
            end
          end
        end
        S_SCAN: begin
          left_r <= left_r - CNT_W'(1);
          step_r <= step_r + IDX_W'(1);
          if (!is_ea_r && match && !found_r) begin
            found_r <= 1'b1;
            fidx_r  <= step_r;
          end
          if (is_ea_r && match) begin
            tail_r    <= tail_dec;
            removed_r <= removed_r + CNT_W'(1);
          end
          if (left_r == CNT_W'(1)) begin
            // Last entry examined: publish the result.
            state_r       <= S_IDLE;
            out_valid_r   <= 1'b1;
            out_status_r  <= alc_pkg::ST_OK;
            out_found_r   <= !is_ea_r && (found_r || match);
            out_fidx_r    <= (!is_ea_r && !found_r && match) ? step_r : fidx_r;
            if (is_ea_r) begin
              count_r       <= match ? tail_dec : tail_r;
              out_len_r     <= match ? tail_dec : tail_r;
              out_removed_r <= match ? removed_r + CNT_W'(1) : removed_r;
            end else begin
              out_len_r     <= count_r;
              out_removed_r <= '0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_found_index = 4'(out_fidx_r);
  assign out_removed     = 5'(out_removed_r);
  assign out_length      = 5'(out_len_r);

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_tail_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (tail_r <= count_r) && (tail_r != '0) && (left_r != '0))
    else $error("scan pointers left the list");

  a_imm_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !go_scan |=> out_valid_r)
    else $error("single-cycle request gave no result");

  a_removed_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_len_r} + {1'b0, out_removed_r}) <= (CNT_W + 1)'(CAPACITY))
    else $error("removed plus length exceeds capacity");
`endif

endmodule

@@ tb/sv/list_result_checker.sv @@
`timescale 1ns / 1ps

module list_result_checker
  import alc_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [3:0]  in_position,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic        out_found,
  input  logic [3:0]  out_found_index,
  input  logic [4:0]  out_removed,
  input  logic [4:0]  out_length,
  output int          mismatch_count,
  output int          pending_results
);

  typedef struct {
    status_t    status;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] removed;
    logic [4:0] length;
  } list_result_t;

  logic [31:0]  list_words [CAPACITY];
  int unsigned  word_count;
  list_result_t expected_list_results [$];

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t apply_list_op(logic [3:0] kind, logic [3:0] pos,
                                                 logic [31:0] value);
    list_result_t r;
    int unsigned  i;
    int unsigned  kept;
    r.status      = ST_OK;
    r.found       = 1'b0;
    r.found_index = '0;
    r.removed     = '0;
    case (kind)
      K_PUSH_FRONT, K_PUSH_BACK, K_INSERT: begin
        if (word_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (kind == K_INSERT && pos > word_count) begin
          r.status = ST_RANGE;
        end else begin
          kept = (kind == K_PUSH_FRONT) ? 0 : (kind == K_PUSH_BACK) ? word_count : pos;
          for (i = word_count; i > kept; i--) list_words[i] = list_words[i - 1];
          list_words[kept] = value;
          word_count++;
        end
      end
      K_POP_FRONT, K_POP_BACK, K_ERASE: begin
        if (word_count == 0) begin
          r.status = ST_EMPTY;
        end else if (kind == K_ERASE && pos >= word_count) begin
          r.status = ST_RANGE;
        end else begin
          if (kind != K_POP_BACK) begin
            kept = (kind == K_POP_FRONT) ? 0 : pos;
            for (i = kept; i + 1 < word_count; i++) list_words[i] = list_words[i + 1];
          end
          word_count--;
        end
      end
      K_FIND: begin
        for (i = 0; i < word_count && !r.found; i++) begin
          if (list_words[i] == value) begin
            r.found       = 1'b1;
            r.found_index = i[3:0];
          end
        end
      end
      K_MODIFY: begin
        if (word_count == 0) r.status = ST_EMPTY;
        else if (pos >= word_count) r.status = ST_RANGE;
        else list_words[pos] = value;
      end
      K_ERASE_ALL: begin
        kept = 0;
        for (i = 0; i < word_count; i++) begin
          if (list_words[i] != value) begin
            list_words[kept] = list_words[i];
            kept++;
          end
        end
        r.removed  = 5'(word_count - kept);
        word_count = kept;
      end
      default: ;
    endcase
    r.length = 5'(word_count);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst_n) begin
      word_count = 0;
      expected_list_results.delete();
      mismatch_count = 0;
    end else begin
      // A result always belongs to an earlier request, so compare before predicting.
      if (out_valid && out_ready) begin
        if (expected_list_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no request outstanding: status %0d length %0d",
                     $realtime, out_status, out_length);
        end else begin
          exp_r = expected_list_results.pop_front();
          if (out_status !== exp_r.status || out_found !== exp_r.found ||
              out_found_index !== exp_r.found_index || out_removed !== exp_r.removed ||
              out_length !== exp_r.length) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch: expected status %0d found %0d index %0d removed %0d length %0d",
                       $realtime, exp_r.status, exp_r.found, exp_r.found_index,
                       exp_r.removed, exp_r.length);
              $display("%0t: mismatch: got status %0d found %0d index %0d removed %0d length %0d",
                       $realtime, out_status, out_found, out_found_index, out_removed,
                       out_length);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_list_results.push_back(apply_list_op(in_kind, in_position, in_value));
    end
    pending_results = expected_list_results.size();
  end

endmodule

@@ tb/sv/array_list_engine_unit_tb.sv @@
`timescale 1ns / 1ps

// Top of the list engine bench. It makes reset, clock and stimulus, and gives
// the verdict; the checker beside the engine predicts and compares every result.
module array_list_engine_unit_tb;

  import alc_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 1280;
  localparam int unsigned PHASE_COUNT  = 3;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Long enough to cover the longest scan, over a full list, with margin.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam realtime     WATCHDOG_NS  = 20_000_000.0;

  // Kinds beyond erase all are not operations; the engine must answer them
  // with an ok status and leave the list alone.
  localparam logic [3:0] FIRST_UNUSED_KIND = 4'd9;
  localparam logic [3:0] LAST_UNUSED_KIND  = 4'd15;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_kind;
  logic [3:0]  in_position;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_found;
  logic [3:0]  out_found_index;
  logic [4:0]  out_removed;
  logic [4:0]  out_length;

  int          mismatch_count;
  int          pending_results;

  // Idle percentages of the two sides, changed from phase to phase, and the
  // number of cycles the receiver still has to hold off.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_cycles;

  // A small pool of values, so that find hits and erase all removes several
  // entries at once. The extremes of the value range are always in it.
  logic [31:0] value_pool [6];

  array_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_found_index(out_found_index),
    .out_removed    (out_removed),
    .out_length     (out_length)
  );

  list_result_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_found_index(out_found_index),
    .out_removed    (out_removed),
    .out_length     (out_length),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Offers one request. Idle cycles come first, each one a falling edge with
  // valid low; then the request is presented and held until the engine takes
  // it. Only one assignment lands on valid at any falling edge.
  task automatic send_request(input logic [3:0] kind, input logic [3:0] pos,
                              input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Chooses an operation. A growing stretch mostly pushes and inserts, so the
  // list tends to run full; a shrinking stretch mostly pops and erases, so it
  // tends to run empty. Unused kinds are sprinkled in as noise.
  function automatic logic [3:0] pick_kind(input bit growing);
    int unsigned r;
    r = $urandom_range(99);
    if (r >= 96) return 4'($urandom_range(LAST_UNUSED_KIND, FIRST_UNUSED_KIND));
    if (r >= 86) return K_FIND;
    if (r >= 78) return K_MODIFY;
    if (r >= 72) return K_ERASE_ALL;
    if (growing) begin
      if (r < 24) return K_PUSH_BACK;
      if (r < 44) return K_PUSH_FRONT;
      if (r < 62) return K_INSERT;
    end else begin
      if (r < 18) return K_POP_FRONT;
      if (r < 36) return K_POP_BACK;
      if (r < 56) return K_ERASE;
      if (r < 62) return K_INSERT;
    end
    r = $urandom_range(2);
    return (r == 0) ? K_POP_FRONT : (r == 1) ? K_PUSH_BACK : K_ERASE;
  endfunction

  // Positions lean toward the low end, where most of them are in range even
  // on a short list, but all sixteen codes show up.
  function automatic logic [3:0] pick_position();
    return $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
  endfunction

  function automatic logic [31:0] pick_value();
    return ($urandom_range(99) < 60) ? value_pool[$urandom_range(5)] : $urandom;
  endfunction

  // The receiver. Outside a hold-off it stalls at the phase's idle rate; a
  // hold-off keeps ready low for a counted number of cycles, long enough for
  // the engine to fill its result register and refuse further requests.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run, even with every find
  // scanning a full list.
  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned burst_left;
    int unsigned phase_items;
    bit          growing;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = K_PUSH_FRONT;
    in_position     = '0;
    in_value        = '0;
    send_idle_pct   = 6;
    recv_idle_pct   = 54;
    hold_off_cycles = 0;
    value_pool[0]   = 32'h8000_0000;
    value_pool[1]   = 32'h7fff_ffff;
    value_pool[2]   = 32'h0000_0000;
    value_pool[3]   = 32'hffff_ffff;
    value_pool[4]   = $urandom;
    value_pool[5]   = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Every removal and modify on the fresh, empty list must
    // report an empty list; find and erase all on it are plain ok.
    send_request(K_POP_FRONT, 4'd0, 32'h0);
    send_request(K_POP_BACK, 4'd0, 32'h0);
    send_request(K_ERASE, 4'd0, 32'h0);
    send_request(K_MODIFY, 4'd0, 32'h1234_5678);
    send_request(K_FIND, 4'd0, 32'h0);
    send_request(K_ERASE_ALL, 4'd0, 32'h0);
    // Insert past the end of an empty list is out of range; at position zero
    // it is allowed.
    send_request(K_INSERT, 4'd1, 32'h5555_aaaa);
    send_request(K_INSERT, 4'd0, 32'h5555_aaaa);
    send_request(K_PUSH_BACK, 4'd0, 32'h7fff_ffff);
    send_request(K_PUSH_FRONT, 4'd15, 32'h8000_0000);
    // Insert at the element count appends; one beyond it is out of range.
    send_request(K_INSERT, 4'd3, 32'hffff_ffff);
    send_request(K_INSERT, 4'd5, 32'h0);
    send_request(K_FIND, 4'd0, 32'hffff_ffff);
    send_request(K_FIND, 4'd0, 32'h0bad_0bad);
    send_request(K_MODIFY, 4'd1, 32'hffff_ffff);
    send_request(K_MODIFY, 4'd4, 32'h0);
    send_request(K_ERASE, 4'd4, 32'h0);
    // Two copies of all ones are in the list now; both must go at once.
    send_request(K_ERASE_ALL, 4'd0, 32'hffff_ffff);
    send_request(K_ERASE, 4'd0, 32'h0);
    send_request(FIRST_UNUSED_KIND, 4'd0, 32'hffff_ffff);
    send_request(LAST_UNUSED_KIND, 4'd15, 32'h0);

    // Random part in three phases of idling: a slow receiver, then a slow
    // sender, then no idling at all. The first two phases each contain one
    // long receiver hold-off while requests keep coming.
    phase_items = RANDOM_ITEMS / PHASE_COUNT;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 6 : 0;
      burst_left    = 0;
      growing       = 1'b1;
      for (sent = 0; sent < phase_items; sent++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 10);
          growing    = ~growing | ($urandom_range(3) == 0);
          value_pool[4 + $urandom_range(1)] = $urandom;
        end
        burst_left--;
        if (phase < 2 && sent == phase_items / 3) hold_off_cycles = HOLD_CYCLES;
        send_request(pick_kind(growing), pick_position(), pick_value());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Every prediction must be matched; then give a late or extra result time
    // to show up before the verdict.
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ array_list_engine_unit.f @@
rtl/core/alc_pkg.sv
rtl/core/alc_cell.sv
rtl/core/array_list_engine_unit.sv
tb/sv/list_result_checker.sv
tb/sv/array_list_engine_unit_tb.sv
